// ----- design/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the pot soft-takeover filter.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int AVG_W       = SAMPLE_BITS + FRAC_BITS;
    localparam int LEVEL_W     = 8;
    localparam int GAIN_W      = 9;
    localparam int COUNT_W     = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 3;

    localparam logic [SAMPLE_BITS-1:0] RAW_MAX   = {SAMPLE_BITS{1'b1}};
    localparam logic [LEVEL_W-1:0]     LEVEL_MIN = 8'd5;
    localparam logic [LEVEL_W-1:0]     LEVEL_SPAN = 8'd250;
    localparam logic [GAIN_W-1:0]      GAIN_FULL = 9'd256;

    // 1/250 as a fixed-point reciprocal for the level-to-position map
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((1 << RECIP_SHIFT) / 250);

    // func codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_REMOTE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PICKUP_WINDOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN  = 3'd4;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_PICKUP_WINDOW   = 12'd96;
    localparam logic [COUNT_W-1:0]    RST_CONFIRM_COUNT   = 4'd3;
    localparam logic [CFG_DATA_W-1:0] RST_NOISE_THRESHOLD = 12'd40;
    localparam logic [CFG_DATA_W-1:0] RST_FORCE_DISTANCE  = 12'd260;
    localparam logic [GAIN_W-1:0]     RST_SMOOTHING_GAIN  = 9'd20;

    // controller to datapath step strobes
    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic lvl;
        logic upd;
    } t_dp_cmd;

endpackage

// ----- design/pst_ctrl.sv -----
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer for one item: load, multiply, accumulate, level, update.
// ----------------------------------------------------------------------------
module pst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pst_pkg::t_dp_cmd o_cmd
);
    import pst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_LVL,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mul  = (r_state == S_MUL);
    assign o_cmd.acc  = (r_state == S_ACC);
    assign o_cmd.lvl  = (r_state == S_LVL);
    assign o_cmd.upd  = (r_state == S_UPD) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result can take the register in the cycle the old one leaves
            if ((r_state == S_UPD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: r_state <= S_LVL;
                S_LVL: r_state <= S_UPD;
                S_UPD: begin
                    // hold until the output register can take the result
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- design/pst_datapath.sv -----
// ----------------------------------------------------------------------------
// pst_datapath
// Config registers, filter state, averaging multipliers, level mapping and
// takeover decision, plus the result payload register.
// ----------------------------------------------------------------------------
module pst_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pst_pkg::t_dp_cmd                    i_cmd,
    input  logic                                i_func,
    input  logic [pst_pkg::SAMPLE_BITS-1:0]     i_raw_sample,
    input  logic [pst_pkg::LEVEL_W-1:0]         i_remote_level,
    input  logic                                i_cfg_valid,
    input  logic [pst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [pst_pkg::LEVEL_W-1:0]         o_level,
    output logic                                o_level_changed,
    output logic                                o_knob_captured,
    output logic [pst_pkg::SAMPLE_BITS-1:0]     o_smoothed_position
);
    import pst_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int PROD_W   = AVG_W + GAIN_W;
    localparam int PRODB_W  = SB + GAIN_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int REM_W    = LEVEL_W + SB;
    localparam int RPROD_W  = REM_W + RECIP_W;
    localparam int MAP_W    = SB + LEVEL_W;
    localparam int CMP_W    = (SB > CFG_DATA_W) ? SB : CFG_DATA_W;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_BITS - 1));

    function automatic logic [SB-1:0] abs_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // config registers
    logic [CFG_DATA_W-1:0] r_pickup_window;
    logic [COUNT_W-1:0]    r_confirm_count;
    logic [CFG_DATA_W-1:0] r_noise_threshold;
    logic [CFG_DATA_W-1:0] r_force_distance;
    logic [GAIN_W-1:0]     r_smoothing_gain;

    // filter state
    logic [AVG_W-1:0]   r_avg;
    logic               r_avg_valid;
    logic [SB-1:0]      r_pos;          // rounded r_avg, kept alongside it
    logic               r_captured;
    logic [COUNT_W-1:0] r_confirm_counter;
    logic [SB-1:0]      r_target;
    logic [SB-1:0]      r_neutral;
    logic               r_neutral_valid;
    logic [SB-1:0]      r_last;
    logic [LEVEL_W-1:0] r_applied;

    // per-item working registers
    logic               r_func;
    logic [SB-1:0]      r_x;
    logic [LEVEL_W-1:0] r_v;
    logic [REM_W-1:0]   r_rem_n;
    logic [GAIN_W-1:0]  r_gain;
    logic [GAIN_W-1:0]  r_gain_inv;
    logic [AVG_W-1:0]   r_avg_op;
    logic [PROD_W-1:0]  r_prod_a;
    logic [PRODB_W-1:0] r_prod_b;
    logic [SB-1:0]      r_rq0;
    logic [LEVEL_W-1:0] r_new_level;
    logic               r_in_window;
    logic               r_forced;
    logic               r_noisy;

    // output payload
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_changed;
    logic               r_out_captured;
    logic [SB-1:0]      r_out_pos;

    // load-stage logic
    logic [LEVEL_W-1:0] w_v_clamped;
    logic [LEVEL_W-1:0] w_v_off;
    logic [REM_W-1:0]   w_rem_n;
    logic [GAIN_W-1:0]  w_gain_eff;

    always_comb begin
        w_v_clamped = (i_remote_level < LEVEL_MIN) ? LEVEL_MIN : i_remote_level;
        w_v_off     = w_v_clamped - LEVEL_MIN;
        // (v - 5) * RAW_MAX as shift and subtract
        w_rem_n     = {w_v_off, {SB{1'b0}}} - REM_W'(w_v_off);
        w_gain_eff  = (r_smoothing_gain > GAIN_FULL) ? GAIN_FULL : r_smoothing_gain;
    end

    // accumulate-stage logic
    logic [RPROD_W-1:0] w_rq_prod;
    logic [SUM_W-1:0]   w_sum;
    logic [AVG_W-1:0]   w_avg_new;
    logic [AVG_W:0]     w_rnd;
    logic [SB:0]        w_pos_full;
    logic [SB-1:0]      w_pos_new;

    always_comb begin
        w_rq_prod  = RPROD_W'(r_rem_n) * RPROD_W'(RECIP_MUL);
        w_sum      = SUM_W'(r_prod_a) + SUM_W'({r_prod_b, {FRAC_BITS{1'b0}}}) + ROUND_HALF;
        w_avg_new  = w_sum[FRAC_BITS +: AVG_W];
        w_rnd      = (AVG_W+1)'(w_avg_new) + (AVG_W+1)'(1 << (FRAC_BITS - 1));
        w_pos_full = w_rnd[AVG_W:FRAC_BITS];
        w_pos_new  = (w_pos_full > (SB+1)'(RAW_MAX)) ? RAW_MAX : w_pos_full[SB-1:0];
    end

    // level-stage logic
    logic [MAP_W-1:0]   w_map;
    logic [LEVEL_W-1:0] w_lq0;
    logic [SB:0]        w_lrem;
    logic [LEVEL_W-1:0] w_lq;
    logic [REM_W-1:0]   w_trem;
    logic [SB-1:0]      w_target_new;

    always_comb begin
        // position * 250 / RAW_MAX: divide by 2^SB, then one correction step
        w_map  = MAP_W'(r_pos) * MAP_W'(LEVEL_SPAN);
        w_lq0  = w_map[MAP_W-1:SB];
        w_lrem = (SB+1)'(w_map[SB-1:0]) + (SB+1)'(w_lq0);
        w_lq   = (w_lrem >= (SB+1)'(RAW_MAX)) ? (w_lq0 + 8'd1) : w_lq0;
        // remainder of the reciprocal quotient stays below twice the span
        w_trem = r_rem_n - REM_W'(REM_W'(r_rq0) * REM_W'(LEVEL_SPAN));
        w_target_new = (w_trem >= REM_W'(LEVEL_SPAN)) ? (r_rq0 + SB'(1)) : r_rq0;
    end

    // update-stage next values
    logic [COUNT_W-1:0] w_cnt_inc;
    logic               n_captured;
    logic [COUNT_W-1:0] n_confirm_counter;
    logic [SB-1:0]      n_last;
    logic [LEVEL_W-1:0] n_applied;
    logic               n_changed;
    logic [SB-1:0]      n_neutral;
    logic               n_neutral_valid;

    always_comb begin
        w_cnt_inc         = r_confirm_counter + COUNT_W'(1);
        n_captured        = r_captured;
        n_confirm_counter = r_confirm_counter;
        n_last            = r_last;
        n_applied         = r_applied;
        n_changed         = 1'b0;
        n_neutral         = r_neutral;
        n_neutral_valid   = r_neutral_valid;
        if (r_func == FUNC_REMOTE) begin
            n_applied         = r_v;
            n_neutral         = r_avg_valid ? r_pos : '0;
            n_neutral_valid   = r_avg_valid;
            n_last            = '0;
            n_captured        = 1'b0;
            n_confirm_counter = '0;
        end else if (!r_captured) begin
            priority if (r_in_window) begin
                if (w_cnt_inc >= r_confirm_count) begin
                    // captured by confirmation: level left as is
                    n_captured        = 1'b1;
                    n_last            = r_pos;
                    n_confirm_counter = '0;
                end else begin
                    n_confirm_counter = w_cnt_inc;
                end
            end else if (r_forced) begin
                n_captured        = 1'b1;
                n_last            = r_pos;
                n_confirm_counter = '0;
                n_applied         = r_new_level;
                n_changed         = (r_new_level != r_applied);
            end else begin
                n_confirm_counter = '0;
            end
        end else if (r_noisy) begin
            n_last    = r_pos;
            n_applied = r_new_level;
            n_changed = (r_new_level != r_applied);
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pickup_window   <= RST_PICKUP_WINDOW;
            r_confirm_count   <= RST_CONFIRM_COUNT;
            r_noise_threshold <= RST_NOISE_THRESHOLD;
            r_force_distance  <= RST_FORCE_DISTANCE;
            r_smoothing_gain  <= RST_SMOOTHING_GAIN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PICKUP_WINDOW:   r_pickup_window   <= i_cfg_data;
                CFG_CONFIRM_COUNT:   r_confirm_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_NOISE_THRESHOLD: r_noise_threshold <= i_cfg_data;
                CFG_FORCE_DISTANCE:  r_force_distance  <= i_cfg_data;
                CFG_SMOOTHING_GAIN:  r_smoothing_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg             <= '0;
            r_avg_valid       <= 1'b0;
            r_pos             <= '0;
            r_captured        <= 1'b0;
            r_confirm_counter <= '0;
            r_target          <= '0;
            r_neutral         <= '0;
            r_neutral_valid   <= 1'b0;
            r_last            <= '0;
            r_applied         <= LEVEL_MIN;
        end else begin
            if (i_cmd.acc && r_func == FUNC_SAMPLE) begin
                r_avg       <= w_avg_new;
                r_avg_valid <= 1'b1;
                r_pos       <= w_pos_new;
            end
            if (i_cmd.lvl && r_func == FUNC_REMOTE) begin
                r_target <= w_target_new;
            end
            if (i_cmd.upd) begin
                r_captured        <= n_captured;
                r_confirm_counter <= n_confirm_counter;
                r_neutral         <= n_neutral;
                r_neutral_valid   <= n_neutral_valid;
                r_last            <= n_last;
                r_applied         <= n_applied;
            end
        end
    end

    // per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_x        <= i_raw_sample;
            r_v        <= w_v_clamped;
            r_rem_n    <= w_rem_n;
            r_gain     <= w_gain_eff;
            r_gain_inv <= GAIN_FULL - w_gain_eff;
            // first sample seeds the average
            r_avg_op   <= r_avg_valid ? r_avg : {i_raw_sample, {FRAC_BITS{1'b0}}};
        end
        if (i_cmd.mul) begin
            r_prod_a <= PROD_W'(r_avg_op) * PROD_W'(r_gain_inv);
            r_prod_b <= PRODB_W'(r_x) * PRODB_W'(r_gain);
        end
        if (i_cmd.acc) begin
            r_rq0 <= w_rq_prod[RECIP_SHIFT +: SB];
        end
        if (i_cmd.lvl) begin
            r_new_level <= w_lq + LEVEL_MIN;
            r_in_window <= CMP_W'(abs_diff(r_pos, r_target)) <= CMP_W'(r_pickup_window);
            r_forced    <= r_neutral_valid &&
                           (CMP_W'(abs_diff(r_pos, r_neutral)) >= CMP_W'(r_force_distance));
            r_noisy     <= CMP_W'(abs_diff(r_pos, r_last)) > CMP_W'(r_noise_threshold);
        end
        if (i_cmd.upd) begin
            r_out_level    <= n_applied;
            r_out_changed  <= n_changed;
            r_out_captured <= n_captured;
            r_out_pos      <= r_pos;
        end
    end

    assign o_level             = r_out_level;
    assign o_level_changed     = r_out_changed;
    assign o_knob_captured     = r_out_captured;
    assign o_smoothed_position = r_out_pos;

endmodule

// ----- design/pot_soft_takeover_filter_top.sv -----
// A result is registered after the multiply, accumulate, level map and update
// states; update holds while the output register is full. The item sequencer
// handles one item at a time and accepts a new one only when back in idle.
// A pending result in the output register does not block the next accept.
// Reset (synchronous, active low): registers to defaults, level 5, no sample.
// ----------------------------------------------------------------------------
// pot_soft_takeover_filter_top
// One potentiometer channel with exponential smoothing and soft takeover.
// ----------------------------------------------------------------------------
module pot_soft_takeover_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic [pst_pkg::SAMPLE_BITS-1:0]     i_raw_sample,
    input  logic [pst_pkg::LEVEL_W-1:0]         i_remote_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pst_pkg::LEVEL_W-1:0]         o_level,
    output logic                                o_level_changed,
    output logic                                o_knob_captured,
    output logic [pst_pkg::SAMPLE_BITS-1:0]     o_smoothed_position,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pst_pkg::*;

    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    pst_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_func              (i_func),
        .i_raw_sample        (i_raw_sample),
        .i_remote_level      (i_remote_level),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_level             (o_level),
        .o_level_changed     (o_level_changed),
        .o_knob_captured     (o_knob_captured),
        .o_smoothed_position (o_smoothed_position)
    );

endmodule

// ----- tb/sv/pot_soft_takeover_filter_top_test.sv -----
// ----------------------------------------------------------------------------
// pot_soft_takeover_filter_top_test
// Self-checking bench for the soft-takeover filter. A directed sweep covers
// remote sets, knob extremes and pickup by confirmation and by force. After it
// comes randomized knob motion under several register settings. Every result
// transaction is checked in order against a typed row or a behavioral predictor.
// ----------------------------------------------------------------------------
module pot_soft_takeover_filter_top_test;
    import pst_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0]     level;
        logic                   changed;
        logic                   captured;
        logic [SAMPLE_BITS-1:0] position;
    } t_knob_result;

    typedef struct packed {
        logic                   func;
        logic [SAMPLE_BITS-1:0] raw;
        logic [LEVEL_W-1:0]     remote;
        logic                   typed;
        t_knob_result           result;
    } t_sweep_row;

    typedef enum {KNOB_TRACK, KNOB_WALK, KNOB_JUMP, KNOB_NOISE} t_knob_motion;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_func;
    logic [SAMPLE_BITS-1:0] i_raw_sample;
    logic [LEVEL_W-1:0]     i_remote_level;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [LEVEL_W-1:0]     o_level;
    logic                   o_level_changed;
    logic                   o_knob_captured;
    logic [SAMPLE_BITS-1:0] o_smoothed_position;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // predictor state and register copies
    int unsigned        avg_fx;
    bit                 avg_valid;
    bit                 captured;
    logic [COUNT_W-1:0] confirm_cnt;
    int unsigned        target_pos;
    int unsigned        neutral_pos;
    bit                 neutral_valid;
    int unsigned        last_pos;
    logic [LEVEL_W-1:0] applied_level;
    int unsigned        win_cfg;
    int unsigned        confirm_cfg;
    int unsigned        noise_cfg;
    int unsigned        force_cfg;
    int unsigned        gain_cfg;

    t_knob_result expected_q[$];
    t_sweep_row   sweep_rows[$];
    int           err_cnt     = 0;
    int           cycle_cnt   = 0;
    int           burst_left  = 1;
    bit           rx_hold_req = 1'b0;

    // typed expectation travels with the payload of the item being offered
    logic         drv_typed;
    t_knob_result drv_expect;

    pot_soft_takeover_filter_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_raw_sample        (i_raw_sample),
        .i_remote_level      (i_remote_level),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_level             (o_level),
        .o_level_changed     (o_level_changed),
        .o_knob_captured     (o_knob_captured),
        .o_smoothed_position (o_smoothed_position),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned pos_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned knob_pos();
        int unsigned p;
        p = (avg_fx + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (p > RAW_MAX) ? 32'(RAW_MAX) : p;
    endfunction

    function automatic bit move_level(input int unsigned p);
        logic [LEVEL_W-1:0] v;
        v = LEVEL_W'(p * LEVEL_SPAN / RAW_MAX + LEVEL_MIN);
        if (v == applied_level)
            return 1'b0;
        applied_level = v;
        return 1'b1;
    endfunction

    function automatic t_knob_result takeover_step(input logic func,
                                                   input logic [SAMPLE_BITS-1:0] raw,
                                                   input logic [LEVEL_W-1:0] remote);
        t_knob_result r;
        int unsigned  g;
        int unsigned  x;
        int unsigned  p;
        int unsigned  lvl;
        bit           in_win;
        bit           forced;
        r.changed = 1'b0;
        if (func == FUNC_SAMPLE) begin
            x = 32'(raw);
            g = (gain_cfg > GAIN_FULL) ? 32'(GAIN_FULL) : gain_cfg;
            if (!avg_valid) begin
                avg_fx    = x << FRAC_BITS;
                avg_valid = 1'b1;
            end
            avg_fx = (avg_fx * (GAIN_FULL - g) + (x << FRAC_BITS) * g
                      + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            p = knob_pos();
            if (!captured) begin
                in_win = pos_gap(p, target_pos) <= win_cfg;
                forced = neutral_valid && pos_gap(p, neutral_pos) >= force_cfg;
                if (in_win) begin
                    confirm_cnt = confirm_cnt + 1'b1;
                    // pickup by confirmation leaves the level alone
                    if (confirm_cnt >= confirm_cfg) begin
                        captured    = 1'b1;
                        last_pos    = p;
                        confirm_cnt = '0;
                    end
                end else if (forced) begin
                    captured    = 1'b1;
                    last_pos    = p;
                    confirm_cnt = '0;
                    r.changed   = move_level(p);
                end else begin
                    confirm_cnt = '0;
                end
            end else if (pos_gap(p, last_pos) > noise_cfg) begin
                last_pos  = p;
                r.changed = move_level(p);
            end
        end else begin
            lvl = 32'(remote);
            if (lvl < LEVEL_MIN)
                lvl = 32'(LEVEL_MIN);
            applied_level = LEVEL_W'(lvl);
            target_pos    = (lvl - LEVEL_MIN) * RAW_MAX / LEVEL_SPAN;
            neutral_valid = avg_valid;
            neutral_pos   = avg_valid ? knob_pos() : 0;
            last_pos      = 0;
            captured      = 1'b0;
            confirm_cnt   = '0;
        end
        r.level    = applied_level;
        r.captured = captured;
        r.position = avg_valid ? SAMPLE_BITS'(knob_pos()) : '0;
        return r;
    endfunction

    // scoreboard: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin : scoreboard
        t_knob_result want;
        t_knob_result got;
        if (!i_rst_n) begin
            avg_fx        = 0;
            avg_valid     = 1'b0;
            captured      = 1'b0;
            confirm_cnt   = '0;
            target_pos    = 0;
            neutral_pos   = 0;
            neutral_valid = 1'b0;
            last_pos      = 0;
            applied_level = LEVEL_MIN;
            win_cfg       = 32'(RST_PICKUP_WINDOW);
            confirm_cfg   = 32'(RST_CONFIRM_COUNT);
            noise_cfg     = 32'(RST_NOISE_THRESHOLD);
            force_cfg     = 32'(RST_FORCE_DISTANCE);
            gain_cfg      = 32'(RST_SMOOTHING_GAIN);
            expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PICKUP_WINDOW:   win_cfg     = 32'(i_cfg_data);
                    CFG_CONFIRM_COUNT:   confirm_cfg = 32'(i_cfg_data[COUNT_W-1:0]);
                    CFG_NOISE_THRESHOLD: noise_cfg   = 32'(i_cfg_data);
                    CFG_FORCE_DISTANCE:  force_cfg   = 32'(i_cfg_data);
                    CFG_SMOOTHING_GAIN:  gain_cfg    = 32'(i_cfg_data[GAIN_W-1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want = takeover_step(i_func, i_raw_sample, i_remote_level);
                if (drv_typed)
                    want = drv_expect;
                expected_q.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                got.level    = o_level;
                got.changed  = o_level_changed;
                got.captured = o_knob_captured;
                got.position = o_smoothed_position;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: level %0d", got.level);
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.level !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, got.level);
                        err_cnt++;
                    end
                    if (got.changed !== want.changed) begin
                        $error("level_changed: expected %0d, actual %0d",
                               want.changed, got.changed);
                        err_cnt++;
                    end
                    if (got.captured !== want.captured) begin
                        $error("knob_captured: expected %0d, actual %0d",
                               want.captured, got.captured);
                        err_cnt++;
                    end
                    if (got.position !== want.position) begin
                        $error("smoothed_position: expected %0d, actual %0d",
                               want.position, got.position);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // result side: stall patterns that change over time, plus a long hold-off on request
    initial begin : result_sink
        int hold_left;
        int mode_left;
        int stall_pct;
        hold_left   = 0;
        mode_left   = 0;
        stall_pct   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(8, 160);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic add_row(input logic func, input logic [SAMPLE_BITS-1:0] raw,
                           input logic [LEVEL_W-1:0] remote, input logic typed,
                           input t_knob_result result);
        t_sweep_row row;
        row.func   = func;
        row.raw    = raw;
        row.remote = remote;
        row.typed  = typed;
        row.result = result;
        sweep_rows.push_back(row);
    endtask

    // returns at the edge where the transaction was accepted; valid is left high
    task automatic send_item(input logic func, input logic [SAMPLE_BITS-1:0] raw,
                             input logic [LEVEL_W-1:0] remote, input logic typed,
                             input t_knob_result result);
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_raw_sample   <= raw;
        i_remote_level <= remote;
        drv_typed      <= typed;
        drv_expect     <= result;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_knob_motion           motion;
        int                     knob;
        int                     motion_left;
        int                     pick;
        logic                   func;
        logic [SAMPLE_BITS-1:0] raw;
        logic [LEVEL_W-1:0]     remote;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_SAMPLE;
        i_raw_sample   = '0;
        i_remote_level = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PICKUP_WINDOW;
        i_cfg_data     = '0;
        drv_typed      = 1'b0;
        drv_expect     = '0;
        motion         = KNOB_TRACK;
        knob           = 0;

        // remote sets before any sample, with clamping at the low end
        add_row(FUNC_REMOTE, 12'h000, 8'd0,   1'b1, t_knob_result'{8'd5,   1'b0, 1'b0, 12'd0});
        add_row(FUNC_REMOTE, 12'hFFF, 8'd255, 1'b1, t_knob_result'{8'd255, 1'b0, 1'b0, 12'd0});
        add_row(FUNC_REMOTE, 12'h000, 8'd4,   1'b1, t_knob_result'{8'd5,   1'b0, 1'b0, 12'd0});
        add_row(FUNC_REMOTE, 12'h000, 8'd255, 1'b1, t_knob_result'{8'd255, 1'b0, 1'b0, 12'd0});
        // first sample seeds the average; three in-window samples capture
        add_row(FUNC_SAMPLE, 12'hFFF, 8'h00, 1'b1,
                t_knob_result'{8'd255, 1'b0, 1'b0, 12'd4095});
        add_row(FUNC_SAMPLE, 12'hFFF, 8'hFF, 1'b1,
                t_knob_result'{8'd255, 1'b0, 1'b0, 12'd4095});
        add_row(FUNC_SAMPLE, 12'hFFF, 8'h00, 1'b1,
                t_knob_result'{8'd255, 1'b0, 1'b1, 12'd4095});
        add_row(FUNC_SAMPLE, 12'h000, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h000, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h555, 8'hAA, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'hAAA, 8'h55, 1'b0, '0);
        // neutral is recorded now; pulling away from it forces capture
        add_row(FUNC_REMOTE, 12'h000, 8'd5,   1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h000, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h000, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h000, 8'h00, 1'b0, '0);
        add_row(FUNC_REMOTE, 12'h000, 8'd128, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'd2014, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'd2014, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'd2014, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'd2014, 8'h00, 1'b0, '0);
        add_row(FUNC_REMOTE, 12'hFFF, 8'hAA, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h800, 8'h00, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'hFFF, 8'h00, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (sweep_rows[i]) begin
            send_item(sweep_rows[i].func, sweep_rows[i].raw, sweep_rows[i].remote,
                      sweep_rows[i].typed, sweep_rows[i].result);
            pace_sender();
        end
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_PICKUP_WINDOW,   12'd0);
                    write_reg(CFG_CONFIRM_COUNT,   12'd0);
                    write_reg(CFG_NOISE_THRESHOLD, 12'd0);
                    write_reg(CFG_FORCE_DISTANCE,  12'd0);
                    write_reg(CFG_SMOOTHING_GAIN,  CFG_DATA_W'(GAIN_FULL));
                    write_reg(CFG_UNMAPPED,        CFG_DATA_W'($urandom_range(0, 4095)));
                end
                1: begin
                    write_reg(CFG_PICKUP_WINDOW,   12'd4095);
                    write_reg(CFG_CONFIRM_COUNT,   12'd15);
                    write_reg(CFG_NOISE_THRESHOLD, 12'd4095);
                    write_reg(CFG_FORCE_DISTANCE,  12'd4095);
                    write_reg(CFG_SMOOTHING_GAIN,  12'd1);
                end
                2: begin
                    // zero gain freezes the average after the seed
                    write_reg(CFG_PICKUP_WINDOW,   RST_PICKUP_WINDOW);
                    write_reg(CFG_CONFIRM_COUNT,   CFG_DATA_W'(RST_CONFIRM_COUNT));
                    write_reg(CFG_NOISE_THRESHOLD, RST_NOISE_THRESHOLD);
                    write_reg(CFG_FORCE_DISTANCE,  RST_FORCE_DISTANCE);
                    write_reg(CFG_SMOOTHING_GAIN,  12'd0);
                end
                3: begin
                    // upper data bits are dropped: confirm becomes 0, gain 511
                    write_reg(CFG_PICKUP_WINDOW,   CFG_DATA_W'($urandom_range(0, 400)));
                    write_reg(CFG_CONFIRM_COUNT,   12'hFF0);
                    write_reg(CFG_NOISE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 120)));
                    write_reg(CFG_FORCE_DISTANCE,  CFG_DATA_W'($urandom_range(0, 900)));
                    write_reg(CFG_SMOOTHING_GAIN,  12'hFFF);
                end
                default: begin
                    write_reg(CFG_PICKUP_WINDOW,   CFG_DATA_W'($urandom_range(0, 400)));
                    write_reg(CFG_CONFIRM_COUNT,   CFG_DATA_W'($urandom_range(0, 4095)));
                    write_reg(CFG_NOISE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 120)));
                    write_reg(CFG_FORCE_DISTANCE,  CFG_DATA_W'($urandom_range(0, 900)));
                    write_reg(CFG_SMOOTHING_GAIN,  CFG_DATA_W'(($urandom_range(0, 3) == 0)
                                                               ? $urandom_range(0, 4095)
                                                               : $urandom_range(1, 48)));
                end
            endcase
            i_cfg_valid <= 1'b0;

            knob        = int'($urandom_range(0, RAW_MAX));
            motion_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 4)
                    rx_hold_req = 1'b1;
                if (n == 3 * PHASE_ITEMS / 4)
                    drain_results();
                if (motion_left == 0) begin
                    motion_left = $urandom_range(4, 30);
                    pick        = $urandom_range(0, 9);
                    if (pick < 4)
                        motion = KNOB_TRACK;
                    else if (pick < 8)
                        motion = KNOB_WALK;
                    else if (pick < 9)
                        motion = KNOB_JUMP;
                    else
                        motion = KNOB_NOISE;
                end
                motion_left--;
                raw    = SAMPLE_BITS'($urandom_range(0, RAW_MAX));
                remote = LEVEL_W'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 6) begin
                    func = FUNC_REMOTE;
                    if ($urandom_range(0, 7) == 0)
                        remote = LEVEL_W'($urandom_range(0, LEVEL_MIN - 1));
                end else begin
                    func = FUNC_SAMPLE;
                    case (motion)
                        KNOB_TRACK: knob = int'(target_pos) + int'($urandom_range(0, 120)) - 60;
                        KNOB_WALK:  knob = knob + int'($urandom_range(0, 400)) - 200;
                        KNOB_JUMP:  knob = int'($urandom_range(0, RAW_MAX));
                        default: ;
                    endcase
                    if (knob < 0)
                        knob = 0;
                    else if (knob > int'(RAW_MAX))
                        knob = int'(RAW_MAX);
                    if (motion != KNOB_NOISE)
                        raw = knob[SAMPLE_BITS-1:0];
                end
                send_item(func, raw, remote, 1'b0, '0);
                pace_sender();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pst_pkg.sv
design/pst_ctrl.sv
design/pst_datapath.sv
design/pot_soft_takeover_filter_top.sv
tb/sv/pot_soft_takeover_filter_top_test.sv
